// ===== hw/rtl/dks_pkg.sv =====
// Shared constants and types for the descending key sorter.
// No dependencies.
`timescale 1ns / 1ps
package dks_pkg;
   localparam int MaxKeys  = 64;
   localparam int KeyBits  = 32;
   localparam int AddrBits = $clog2(MaxKeys);
   localparam int CntBits  = $clog2(MaxKeys + 1);

   typedef logic [KeyBits-1:0]  key_type;
   typedef logic [AddrBits-1:0] addr_type;
   typedef logic [CntBits-1:0]  cnt_type;

   // Memory access request from the sequencer.
   typedef struct packed {
      logic     wr_en;
      addr_type wr_addr;
      key_type  wr_data;
      addr_type rd_addr;
   } mem_req_type;

   // Signed greater-than on keys.
   function automatic logic key_gt(key_type a, key_type b);
      return $signed(a) > $signed(b);
   endfunction
endpackage

// ===== hw/rtl/dks_key_ram.sv =====
// Single-port-write, single-port-read key memory, registered read.
// Depends on dks_pkg.
`timescale 1ns / 1ps
module dks_key_ram
   import dks_pkg::*;
(
   input  logic        clock,
   input  mem_req_type mem_req,
   output key_type     rd_data
);
   key_type mem [MaxKeys];

   // Write port and registered read port
   always_ff @(posedge clock) begin
      if (mem_req.wr_en) begin
         mem[mem_req.wr_addr] <= mem_req.wr_data;
      end
      rd_data <= mem[mem_req.rd_addr];
   end
endmodule

// ===== hw/rtl/descending_key_sorter.sv =====
// Descending key sorter: loads signed Q16.16 keys into a 64-entry memory,
// insertion-sorts them in place after the final beat, then emits them.
// Loading: one beat per cycle. Sort: per element RDCUR, GETC, CMP, and WAIT
// after each shift of a predecessor (the memory read is registered). Emit:
// RDOUT then EMIT per key, held while the previous key is not yet taken.
// Reset (synchronous, active high) clears count, flag and state; the key
// memory is not cleared, only entries written in the current set are read.
`timescale 1ns / 1ps
module descending_key_sorter
   import dks_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  key_type req_key,
   input  logic    req_is_final,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output key_type rsp_sorted_key,
   output logic    rsp_end_of_run,
   output logic    rsp_overflow
);
   typedef enum logic [6:0] {
      S_LOAD  = 7'b0000001,
      S_RDCUR = 7'b0000010,
      S_GETC  = 7'b0000100,
      S_CMP   = 7'b0001000,
      S_RDOUT = 7'b0010000,
      S_EMIT  = 7'b0100000,
      S_WAIT  = 7'b1000000
   } state_type;

   state_type   state_ff, state_in;
   cnt_type     count_ff, count_in;
   logic        drop_ff, drop_in;
   cnt_type     i_ff, i_in;      // outer index
   cnt_type     j_ff, j_in;      // insertion position
   key_type     cur_ff, cur_in;
   key_type     rsp_key_ff, rsp_key_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic        rsp_end_ff, rsp_end_in;
   logic        rsp_ovf_ff, rsp_ovf_in;
   mem_req_type mem_req;
   key_type     rd_data;

   dks_key_ram u_ram (.clock(clock), .mem_req(mem_req), .rd_data(rd_data));

   assign req_ready      = (state_ff == S_LOAD);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_sorted_key = rsp_key_ff;
   assign rsp_end_of_run = rsp_end_ff;
   assign rsp_overflow   = rsp_ovf_ff;

   // Sequencer: load, insertion sort, emit
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      drop_in      = drop_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      cur_in       = cur_ff;
      rsp_key_in   = rsp_key_ff;
      rsp_end_in   = rsp_end_ff;
      rsp_ovf_in   = rsp_ovf_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      mem_req      = '{wr_en: 1'b0, wr_addr: count_ff[AddrBits-1:0],
                       wr_data: req_key, rd_addr: i_ff[AddrBits-1:0]};
      unique case (state_ff)
         S_LOAD: begin
            if (req_valid) begin
               if (count_ff < cnt_type'(MaxKeys)) begin
                  mem_req.wr_en = 1'b1;
                  count_in      = count_ff + 1'b1;
               end else begin
                  drop_in = 1'b1;
               end
               if (req_is_final) begin
                  i_in     = cnt_type'(1);
                  state_in = S_RDCUR;
               end
            end
         end
         S_RDCUR: begin
            // read element i, or start emitting when done
            if (i_ff >= count_ff) begin
               i_in     = '0;
               state_in = S_RDOUT;
            end else begin
               mem_req.rd_addr = i_ff[AddrBits-1:0];
               j_in            = i_ff;
               state_in        = S_GETC;
            end
         end
         S_GETC: begin
            cur_in          = rd_data;
            mem_req.rd_addr = AddrBits'(j_ff - 1'b1);
            state_in        = S_CMP;
         end
         S_CMP: begin
            // shift predecessor up, or drop current into its slot
            mem_req.wr_addr = j_ff[AddrBits-1:0];
            mem_req.wr_en   = 1'b1;
            if (key_gt(cur_ff, rd_data)) begin
               mem_req.wr_data = rd_data;
               mem_req.rd_addr = AddrBits'(j_ff - 2'd2);
               j_in            = j_ff - 1'b1;
               state_in        = S_WAIT;
            end else begin
               mem_req.wr_data = cur_ff;
               i_in            = i_ff + 1'b1;
               state_in        = S_RDCUR;
            end
         end
         S_WAIT: begin
            // after a shift: either insert at slot 0 or compare again
            if (j_ff == '0) begin
               mem_req.wr_en   = 1'b1;
               mem_req.wr_addr = '0;
               mem_req.wr_data = cur_ff;
               i_in            = i_ff + 1'b1;
               state_in        = S_RDCUR;
            end else begin
               mem_req.rd_addr = AddrBits'(j_ff - 1'b1);
               state_in        = S_CMP;
            end
         end
         S_RDOUT: begin
            mem_req.rd_addr = i_ff[AddrBits-1:0];
            if (!rsp_valid_ff || rsp_ready) begin
               state_in = S_EMIT;
            end
         end
         S_EMIT: begin
            rsp_valid_in = 1'b1;
            rsp_key_in   = rd_data;
            rsp_ovf_in   = drop_ff;
            rsp_end_in   = (i_ff + 1'b1 == count_ff);
            i_in         = i_ff + 1'b1;
            if (i_ff + 1'b1 == count_ff) begin
               count_in = '0;
               drop_in  = 1'b0;
               state_in = S_LOAD;
            end else begin
               state_in = S_RDOUT;
            end
         end
         default: state_in = S_LOAD;
      endcase
   end

   // Hold control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_LOAD;
         count_ff     <= '0;
         drop_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         drop_ff      <= drop_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Advance payload registers
   always_ff @(posedge clock) begin
      i_ff       <= i_in;
      j_ff       <= j_in;
      cur_ff     <= cur_in;
      rsp_key_ff <= rsp_key_in;
      rsp_end_ff <= rsp_end_in;
      rsp_ovf_ff <= rsp_ovf_in;
   end

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= cnt_type'(MaxKeys)) else $error("count beyond capacity");
   a_no_emit_empty: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_EMIT |-> count_ff != '0) else $error("emit with empty set");
   a_end_clears: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_EMIT && rsp_end_in |=> count_ff == '0 && !drop_ff)
      else $error("run end did not clear set");
endmodule
